[rtl/pwtx_pkg.sv]
// shared types and constants of the pulse width radio transmitter
package pwtx_pkg;

   localparam int FRAME_BYTES     = 5;
   localparam int FRAME_BITS      = FRAME_BYTES * 8;
   localparam int TRAILER_SYMBOLS = 3;
   localparam int SYMBOL_TOTAL    = 1 + FRAME_BITS + TRAILER_SYMBOLS;
   localparam int SYM_W           = $clog2(SYMBOL_TOTAL + 1);
   localparam int QUEUE_DEPTH     = 2;
   localparam int CSR_IDX_W       = 3;

   localparam logic [7:0] POWER_MAX = 8'd99;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BIT_PER   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PRE_HIGH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PRE_PER   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WAKE_EN   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PRE_WAIT  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_POST_WAIT = 3'd7;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_PRE   = 3'd1,
      PH_PULSE = 3'd2,
      PH_POST  = 3'd3,
      PH_SYM   = 3'd4
   } phase_type;

   // classified command between front and sequencer
   typedef struct packed {
      logic                  start;
      logic [FRAME_BITS-1:0] frame;
   } cmd_type;

   // one result transaction
   typedef struct packed {
      logic pin_level;
      logic busy_res;
      logic start_rejected;
      logic frame_done;
   } rsp_type;

endpackage

[rtl/pwtx_front.sv]
// front end: accepts request transactions and packs start frames
module pwtx_front (
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,
   input  logic             req_tuser,
   input  logic             queue_full,
   output logic             push,
   output pwtx_pkg::cmd_type cmd
);
   import pwtx_pkg::*;

   logic [15:0] secret;
   logic [2:0]  channel;
   logic [2:0]  command_kind;
   logic [7:0]  power;
   logic [7:0]  b0, b1, b2, b3, b4;

   assign secret       = req_tdata[15:0];
   assign channel      = req_tdata[18:16];
   assign command_kind = req_tdata[21:19];
   assign power        = req_tdata[29:22];

   assign b0 = secret[15:8];
   assign b1 = secret[7:0];
   assign b2 = {1'b0, channel, 1'b0, command_kind};
   assign b3 = (power > POWER_MAX) ? POWER_MAX : power;
   assign b4 = b0 + b1 + b2 + b3;

   assign req_tready = ~queue_full;
   assign push       = req_tvalid & ~queue_full;
   assign cmd.start  = req_tuser;
   assign cmd.frame  = {b0, b1, b2, b3, b4};

endmodule

[rtl/pwtx_queue.sv]
// two-entry command queue between front end and sequencer
module pwtx_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pwtx_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output pwtx_pkg::cmd_type head_cmd
);
   import pwtx_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type              store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = store_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = do_push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/pwtx_seq.sv]
// back end: waveform sequencer with result register
module pwtx_seq #(
   parameter int TIME_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [TIME_WIDTH-1:0] one_high_time,
   input  logic [TIME_WIDTH-1:0] zero_high_time,
   input  logic [TIME_WIDTH-1:0] bit_period,
   input  logic [TIME_WIDTH-1:0] preamble_high_time,
   input  logic [TIME_WIDTH-1:0] preamble_period,
   input  logic                  wake_pulse_enable,
   input  logic [TIME_WIDTH-1:0] pre_wait_time,
   input  logic [TIME_WIDTH-1:0] post_wait_time,
   input  logic                  head_valid,
   input  pwtx_pkg::cmd_type     head_cmd,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pwtx_pkg::rsp_type     rsp
);
   import pwtx_pkg::*;

   // derived bit timings, refreshed every cycle from the registers
   logic [TIME_WIDTH-1:0] der_one, der_zero, der_per;
   logic [TIME_WIDTH:0]   high_sum;
   logic [TIME_WIDTH-1:0] one_len, zero_len, pre_len;
   logic [TIME_WIDTH-1:0] one_high_ff, zero_high_ff;
   logic [TIME_WIDTH-1:0] one_len_ff, zero_len_ff, pre_len_ff;

   phase_type             phase_ff, phase_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [SYM_W-1:0]      sym_ff, sym_in, sym_inc;
   logic [TIME_WIDTH-1:0] tick_ff, tick_in, tick_inc;
   logic                  level_ff, level_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  step, is_start, is_tick;
   logic [TIME_WIDTH-1:0] sym_high, sym_len;
   logic                  sym_end, last_sym, pre_end, post_end;

   function automatic logic [TIME_WIDTH-1:0] len_of(input logic [TIME_WIDTH-1:0] h,
                                                    input logic [TIME_WIDTH-1:0] p);
      logic [TIME_WIDTH-1:0] m;
      m = (h > p) ? h : p;
      return (m == '0) ? TIME_WIDTH'(1) : m;
   endfunction

   always_comb begin
      der_one  = one_high_time;
      der_zero = zero_high_time;
      der_per  = bit_period;
      high_sum = {1'b0, one_high_time} + {1'b0, zero_high_time};
      if (one_high_time == '0) begin
         der_one = (bit_period > zero_high_time) ? bit_period - zero_high_time : '0;
      end else if (zero_high_time == '0) begin
         der_zero = (bit_period > one_high_time) ? bit_period - one_high_time : '0;
      end else if (bit_period == '0) begin
         der_per = high_sum[TIME_WIDTH] ? '1 : high_sum[TIME_WIDTH-1:0];
      end
   end

   assign one_len  = len_of(der_one, der_per);
   assign zero_len = len_of(der_zero, der_per);
   assign pre_len  = len_of(preamble_high_time, preamble_period);

   always_ff @(posedge clock) begin
      one_high_ff  <= der_one;
      zero_high_ff <= der_zero;
      one_len_ff   <= one_len;
      zero_len_ff  <= zero_len;
      pre_len_ff   <= pre_len;
   end

   // a command is taken when the result register is free or draining
   assign step     = head_valid & (~rsp_valid_ff | rsp_ready);
   assign pop      = step;
   assign is_start = step & head_cmd.start;
   assign is_tick  = step & ~head_cmd.start;

   // current symbol: preamble, data bit from the top of the shifter, or trailer zero
   always_comb begin
      if (sym_ff == '0) begin
         sym_high = preamble_high_time;
         sym_len  = pre_len_ff;
      end else if (sym_ff <= SYM_W'(FRAME_BITS) && frame_ff[FRAME_BITS-1]) begin
         sym_high = one_high_ff;
         sym_len  = one_len_ff;
      end else begin
         sym_high = zero_high_ff;
         sym_len  = zero_len_ff;
      end
   end

   assign tick_inc = tick_ff + 1'b1;
   assign sym_inc  = sym_ff + 1'b1;
   assign sym_end  = (tick_inc >= sym_len);
   assign last_sym = (sym_inc >= SYM_W'(SYMBOL_TOTAL));
   assign pre_end  = (tick_inc >= pre_wait_time);
   assign post_end = (tick_inc >= post_wait_time);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (is_start) begin
         if (phase_ff == PH_IDLE) begin
            if (wake_pulse_enable) begin
               phase_in = (pre_wait_time != '0) ? PH_PRE : PH_PULSE;
            end else begin
               phase_in = PH_SYM;
            end
         end
      end else if (is_tick) begin
         unique case (phase_ff)
            PH_PRE:   phase_in = pre_end ? PH_PULSE : PH_PRE;
            PH_PULSE: phase_in = (post_wait_time != '0) ? PH_POST : PH_SYM;
            PH_POST:  phase_in = post_end ? PH_SYM : PH_POST;
            PH_SYM:   phase_in = (sym_end && last_sym) ? PH_IDLE : PH_SYM;
            default:  phase_in = PH_IDLE;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      frame_in       = frame_ff;
      sym_in         = sym_ff;
      tick_in        = tick_ff;
      level_in       = level_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in.start_rejected = 1'b0;
      rsp_in.frame_done     = 1'b0;
      if (is_start) begin
         if (phase_ff == PH_IDLE) begin
            frame_in = head_cmd.frame;
            sym_in   = '0;
            tick_in  = '0;
            level_in = 1'b0;
         end else begin
            rsp_in.start_rejected = 1'b1;
         end
      end else if (is_tick) begin
         unique case (phase_ff)
            PH_PRE: begin
               level_in = 1'b0;
               tick_in  = pre_end ? '0 : tick_inc;
            end
            PH_PULSE: begin
               level_in = 1'b1;
               tick_in  = '0;
            end
            PH_POST: begin
               level_in = 1'b0;
               tick_in  = post_end ? '0 : tick_inc;
            end
            PH_SYM: begin
               level_in = (tick_ff < sym_high);
               tick_in  = sym_end ? '0 : tick_inc;
               if (sym_end) begin
                  if (sym_ff != '0 && sym_ff <= SYM_W'(FRAME_BITS)) begin
                     frame_in = {frame_ff[FRAME_BITS-2:0], 1'b0};
                  end
                  if (last_sym) begin
                     sym_in            = '0;
                     rsp_in.frame_done = 1'b1;
                  end else begin
                     sym_in = sym_inc;
                  end
               end
            end
            default: level_in = 1'b0;
         endcase
      end
      if (step) begin
         rsp_in.pin_level = level_in;
         rsp_in.busy_res  = (phase_in != PH_IDLE);
         rsp_valid_in     = 1'b1;
      end else begin
         rsp_in       = rsp_ff;
         rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         sym_ff       <= '0;
         tick_ff      <= '0;
         level_ff     <= 1'b0;
         frame_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sym_ff       <= sym_in;
         tick_ff      <= tick_in;
         level_ff     <= level_in;
         frame_ff     <= frame_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[rtl/pulse_width_rf_message_transmitter_top.sv]
// top level of the pulse width on-off-keyed radio frame transmitter
//
// req channel: one transaction per item; tuser = 1 starts a frame (tdata carries
// secret, channel, kind, power), tuser = 0 is one microsecond tick of waveform.
// rsp channel: exactly one transaction per request: line level, busy, start
// rejected in tdata, and tlast high on the tick that ends the last trailer symbol.
// csr port: write-only, index 0..7 selects the timing register, taken every
// cycle csr_wen is high; write only while the block is idle.
// throughput: one request per clock while the queue is not full; the front end classifies and
// packs the frame, a two-entry queue feeds the sequencer and keeps taking
// requests while an older result waits in the result register.
// path: an accepted request is written into the queue register, and the sequencer
// writes its result into the result register once the command is at the queue
// head and the result register is free or draining.
// timing registers are turned into registered bit lengths after a write.
// reset: synchronous, clears the queue, sequencer (idle, line low) and the timing
// registers to zero; the result data and derived bit lengths are not reset.
// a stalled rsp side fills the queue, then req_tready drops; nothing is lost.
module pulse_width_rf_message_transmitter_top #(
   parameter int TIME_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,  // secret, channel, command_kind, power
   input  logic                           req_tuser,  // operation
   // result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,  // pin_level, busy_res, start_rejected
   output logic                           rsp_tlast,  // frame_done
   // configuration writes
   input  logic                           csr_wen,
   input  logic [pwtx_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_WIDTH-1:0]          csr_wdata
);
   import pwtx_pkg::*;

   // timing registers
   logic [TIME_WIDTH-1:0] one_high_ff, zero_high_ff, bit_per_ff;
   logic [TIME_WIDTH-1:0] pre_high_ff, pre_per_ff, pre_wait_ff, post_wait_ff;
   logic                  wake_en_ff;

   logic    push, queue_full, pop, head_valid, rsp_valid;
   cmd_type push_cmd, head_cmd;
   rsp_type rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         one_high_ff  <= '0;
         zero_high_ff <= '0;
         bit_per_ff   <= '0;
         pre_high_ff  <= '0;
         pre_per_ff   <= '0;
         wake_en_ff   <= 1'b0;
         pre_wait_ff  <= '0;
         post_wait_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_ONE_HIGH:  one_high_ff  <= csr_wdata;
            REG_ZERO_HIGH: zero_high_ff <= csr_wdata;
            REG_BIT_PER:   bit_per_ff   <= csr_wdata;
            REG_PRE_HIGH:  pre_high_ff  <= csr_wdata;
            REG_PRE_PER:   pre_per_ff   <= csr_wdata;
            REG_WAKE_EN:   wake_en_ff   <= csr_wdata[0];
            REG_PRE_WAIT:  pre_wait_ff  <= csr_wdata;
            REG_POST_WAIT: post_wait_ff <= csr_wdata;
            default:       wake_en_ff   <= wake_en_ff;
         endcase
      end
   end

   // front end: accept and pack
   pwtx_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   // decoupling queue
   pwtx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // back end: waveform sequencer
   pwtx_seq #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .one_high_time      (one_high_ff),
      .zero_high_time     (zero_high_ff),
      .bit_period         (bit_per_ff),
      .preamble_high_time (pre_high_ff),
      .preamble_period    (pre_per_ff),
      .wake_pulse_enable  (wake_en_ff),
      .pre_wait_time      (pre_wait_ff),
      .post_wait_time     (post_wait_ff),
      .head_valid         (head_valid),
      .head_cmd           (head_cmd),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_tready),
      .rsp                (rsp)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = {5'b0, rsp.start_rejected, rsp.busy_res, rsp.pin_level};
   assign rsp_tlast  = rsp.frame_done;

endmodule

[bench/pulse_width_rf_message_transmitter_top_test.sv]
// self-checking testbench of the pulse width radio frame transmitter
`timescale 1ns / 100ps

module pulse_width_rf_message_transmitter_top_test;
   import pwtx_pkg::*;

   localparam int TIME_W        = 16;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 4;    // settle time through queue and result register, plus margin
   localparam int MAX_REPORTS   = 40;
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   // timing register file as the block sees it
   typedef struct packed {
      logic [TIME_W-1:0] one_high;
      logic [TIME_W-1:0] zero_high;
      logic [TIME_W-1:0] bit_per;
      logic [TIME_W-1:0] pre_high;
      logic [TIME_W-1:0] pre_per;
      logic              wake_en;
      logic [TIME_W-1:0] pre_wait;
      logic [TIME_W-1:0] post_wait;
   } timing_regs_type;

   // one row of the directed stimulus
   typedef struct packed {
      logic        op;
      logic [15:0] secret;
      logic [2:0]  chan;
      logic [2:0]  kind;
      logic [7:0]  power;
      logic        typed;   // check against want instead of the predictor
      rsp_type     want;
      logic        drain;   // follow with ticks until the frame ends
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [31:0]       req_tdata;
   logic              req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;
   logic              rsp_tlast;
   logic              csr_wen;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TIME_W-1:0] csr_wdata;

   // predictor state
   timing_regs_type       tx_cfg;
   phase_type             tx_phase;
   logic [FRAME_BITS-1:0] tx_frame;
   int unsigned           tx_symbol;
   logic [TIME_W-1:0]     tx_ticks;
   logic                  tx_line;

   // expected results in order of acceptance
   rsp_type due_results[$];
   rsp_type seen_rsp, due_rsp;

   stim_row_type stim_rows[$];

   int snd_idle_pct, rcv_idle_pct;
   int unsigned errors, results_checked, items_sent, frames_done, starts_dropped;
   int unsigned settings_used, cycle_count;

   pulse_width_rf_message_transmitter_top #(
      .TIME_WIDTH(TIME_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type pack_result(input logic pin, input logic busy,
                                           input logic rejected, input logic done);
      rsp_type r;
      r.pin_level      = pin;
      r.busy_res       = busy;
      r.start_rejected = rejected;
      r.frame_done     = done;
      return r;
   endfunction

   function automatic timing_regs_type make_timing(
         input int one_high, input int zero_high, input int bit_per,
         input int pre_high, input int pre_per, input int wake_en,
         input int pre_wait, input int post_wait);
      timing_regs_type t;
      t.one_high  = TIME_W'(one_high);
      t.zero_high = TIME_W'(zero_high);
      t.bit_per   = TIME_W'(bit_per);
      t.pre_high  = TIME_W'(pre_high);
      t.pre_per   = TIME_W'(pre_per);
      t.wake_en   = wake_en[0];
      t.pre_wait  = TIME_W'(pre_wait);
      t.post_wait = TIME_W'(post_wait);
      return t;
   endfunction

   function automatic stim_row_type make_row(
         input logic op, input logic [15:0] secret, input logic [2:0] chan,
         input logic [2:0] kind, input logic [7:0] power, input logic typed,
         input rsp_type want, input logic drain);
      stim_row_type s;
      s.op = op;  s.secret = secret;  s.chan = chan;  s.kind = kind;
      s.power = power;  s.typed = typed;  s.want = want;  s.drain = drain;
      return s;
   endfunction

   // advance the transmit waveform by one transaction and return its result
   function automatic rsp_type advance_waveform(
         input logic op, input logic [15:0] secret, input logic [2:0] chan,
         input logic [2:0] kind, input logic [7:0] power);
      rsp_type           r;
      logic [7:0]        b0, b1, b2, b3, b4;
      logic [TIME_W-1:0] one_t, zero_t, per_t, high_t, len_t;
      logic [TIME_W:0]   sum;
      r = '0;
      if (op == OP_START) begin
         if (tx_phase != PH_IDLE) begin
            r.start_rejected = 1'b1;   // busy: frame goes on untouched
         end else begin
            b0 = secret[15:8];
            b1 = secret[7:0];
            b2 = {1'b0, chan, 1'b0, kind};
            b3 = (power > POWER_MAX) ? POWER_MAX : power;
            b4 = b0 + b1 + b2 + b3;
            tx_frame  = {b0, b1, b2, b3, b4};
            tx_ticks  = '0;
            tx_symbol = 0;
            tx_line   = 1'b0;
            if (tx_cfg.wake_en)
               tx_phase = (tx_cfg.pre_wait != '0) ? PH_PRE : PH_PULSE;
            else
               tx_phase = PH_SYM;
         end
      end else begin
         case (tx_phase)
            PH_PRE: begin
               tx_line  = 1'b0;
               tx_ticks = tx_ticks + 1'b1;
               if (tx_ticks >= tx_cfg.pre_wait) begin
                  tx_ticks = '0;
                  tx_phase = PH_PULSE;
               end
            end
            PH_PULSE: begin
               tx_line  = 1'b1;
               tx_ticks = '0;
               tx_phase = (tx_cfg.post_wait != '0) ? PH_POST : PH_SYM;
            end
            PH_POST: begin
               tx_line  = 1'b0;
               tx_ticks = tx_ticks + 1'b1;
               if (tx_ticks >= tx_cfg.post_wait) begin
                  tx_ticks = '0;
                  tx_phase = PH_SYM;
               end
            end
            PH_SYM: begin
               // bit timings: a zero register is filled in from the other two
               one_t  = tx_cfg.one_high;
               zero_t = tx_cfg.zero_high;
               per_t  = tx_cfg.bit_per;
               if (one_t == '0) begin
                  one_t = (per_t > zero_t) ? per_t - zero_t : '0;
               end else if (zero_t == '0) begin
                  zero_t = (per_t > one_t) ? per_t - one_t : '0;
               end else if (per_t == '0) begin
                  sum   = {1'b0, one_t} + {1'b0, zero_t};
                  per_t = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
               end
               if (tx_symbol == 0) begin
                  high_t = tx_cfg.pre_high;
                  per_t  = tx_cfg.pre_per;
               end else if (tx_symbol <= FRAME_BITS) begin
                  high_t = tx_frame[FRAME_BITS - tx_symbol] ? one_t : zero_t;
               end else begin
                  high_t = zero_t;     // trailer
               end
               len_t = (high_t > per_t) ? high_t : per_t;
               if (len_t == '0)
                  len_t = TIME_W'(1);  // empty symbol still takes one low tick
               tx_line  = (tx_ticks < high_t);
               tx_ticks = tx_ticks + 1'b1;
               if (tx_ticks >= len_t) begin
                  tx_ticks  = '0;
                  tx_symbol = tx_symbol + 1;
                  if (tx_symbol >= SYMBOL_TOTAL) begin
                     tx_symbol    = 0;
                     tx_phase     = PH_IDLE;
                     r.frame_done = 1'b1;
                  end
               end
            end
            default: begin
               tx_phase = PH_IDLE;
               tx_line  = 1'b0;
            end
         endcase
      end
      r.pin_level = tx_line;
      r.busy_res  = (tx_phase != PH_IDLE);
      return r;
   endfunction

   // one request transaction with random sender gaps in front of it
   task automatic send_item(input logic op, input logic [15:0] secret,
                            input logic [2:0] chan, input logic [2:0] kind,
                            input logic [7:0] power, input logic typed,
                            input rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, power, kind, chan, secret};
      do @(posedge clock); while (!req_tready);
      predicted = advance_waveform(op, secret, chan, kind, power);
      items_sent++;
      if (predicted.frame_done)
         frames_done++;
      if (predicted.start_rejected)
         starts_dropped++;
      due_results.push_back(typed ? want : predicted);
   endtask

   function automatic logic [7:0] pick_power();
      // lean on the saturation boundary now and then
      if ($urandom_range(7) != 0)
         return 8'($urandom_range(255));
      case ($urandom_range(4))
         0:       return 8'd0;
         1:       return POWER_MAX - 8'd1;
         2:       return POWER_MAX;
         3:       return POWER_MAX + 8'd1;
         default: return 8'd255;
      endcase
   endfunction

   // tick data is ignored by the block, so it carries random noise
   task automatic send_tick();
      send_item(OP_TICK, 16'($urandom), 3'($urandom), 3'($urandom), 8'($urandom),
                1'b0, '0);
   endtask

   task automatic send_start();
      send_item(OP_START, 16'($urandom), 3'($urandom), 3'($urandom), pick_power(),
                1'b0, '0);
   endtask

   // start a frame and tick it to the end, with the odd start thrown in while busy
   task automatic run_frame();
      send_start();
      while (tx_phase != PH_IDLE) begin
         if ($urandom_range(99) < 3)
            send_start();
         else
            send_tick();
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [TIME_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // reprogram all timing registers once the block has gone quiet
   task automatic apply_timing(input timing_regs_type t);
      req_tvalid <= 1'b0;
      while (due_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(REG_ONE_HIGH,  t.one_high);
      write_csr(REG_ZERO_HIGH, t.zero_high);
      write_csr(REG_BIT_PER,   t.bit_per);
      write_csr(REG_PRE_HIGH,  t.pre_high);
      write_csr(REG_PRE_PER,   t.pre_per);
      write_csr(REG_WAKE_EN,   {{(TIME_W-1){1'b0}}, t.wake_en});
      write_csr(REG_PRE_WAIT,  t.pre_wait);
      write_csr(REG_POST_WAIT, t.post_wait);
      csr_wen <= 1'b0;
      tx_cfg = t;
      settings_used++;
      // bit lengths are derived and registered after the write
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: random backpressure and in-order checking
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_rsp = pack_result(rsp_tdata[0], rsp_tdata[1], rsp_tdata[2], rsp_tlast);
         results_checked++;
         if (due_results.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: result with nothing expected: got %b", $time, seen_rsp);
         end else begin
            due_rsp = due_results.pop_front();
            if (seen_rsp !== due_rsp) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: result %0d expected pin %b busy %b rej %b done %b, %s %b %b %b %b",
                           $time, results_checked, due_rsp.pin_level, due_rsp.busy_res,
                           due_rsp.start_rejected, due_rsp.frame_done, "got",
                           seen_rsp.pin_level, seen_rsp.busy_res,
                           seen_rsp.start_rejected, seen_rsp.frame_done);
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d results outstanding", $time, due_results.size());
         $display("pulse_width_rf_message_transmitter_top_test: errors");
         $finish;
      end
   end

   initial begin
      timing_regs_type t;
      int unsigned     random_base;
      int unsigned     setting_no;
      items_sent = 0;  frames_done = 0;  starts_dropped = 0;  settings_used = 0;
      snd_idle_pct = 29;
      rcv_idle_pct = 55;
      // predictor matches the reset state
      tx_cfg    = '0;
      tx_phase  = PH_IDLE;
      tx_frame  = '0;
      tx_symbol = 0;
      tx_ticks  = '0;
      tx_line   = 1'b0;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_TICK;
      csr_wen    <= 1'b0;
      csr_index  <= REG_ONE_HIGH;
      csr_wdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part on reset timings: every symbol is one empty low tick
      stim_rows.push_back(make_row(OP_TICK, 16'h0000, 3'd0, 3'd0, 8'd0, 1'b1,
                                   pack_result(1'b0, 1'b0, 1'b0, 1'b0), 1'b0));
      stim_rows.push_back(make_row(OP_START, 16'hffff, 3'd7, 3'd7, 8'd255, 1'b1,
                                   pack_result(1'b0, 1'b1, 1'b0, 1'b0), 1'b0));
      stim_rows.push_back(make_row(OP_START, 16'h0000, 3'd0, 3'd0, 8'd0, 1'b1,
                                   pack_result(1'b0, 1'b1, 1'b1, 1'b0), 1'b0));
      stim_rows.push_back(make_row(OP_TICK, 16'h1234, 3'd1, 3'd2, 8'd3, 1'b0, '0, 1'b0));
      stim_rows.push_back(make_row(OP_TICK, 16'h0000, 3'd0, 3'd0, 8'd0, 1'b0, '0, 1'b1));
      stim_rows.push_back(make_row(OP_TICK, 16'hffff, 3'd7, 3'd7, 8'd255, 1'b1,
                                   pack_result(1'b0, 1'b0, 1'b0, 1'b0), 1'b0));
      stim_rows.push_back(make_row(OP_START, 16'h0000, 3'd0, 3'd0, 8'd0, 1'b1,
                                   pack_result(1'b0, 1'b1, 1'b0, 1'b0), 1'b1));
      stim_rows.push_back(make_row(OP_START, 16'ha55a, 3'd5, 3'd2, POWER_MAX, 1'b1,
                                   pack_result(1'b0, 1'b1, 1'b0, 1'b0), 1'b0));
      stim_rows.push_back(make_row(OP_START, 16'h5aa5, 3'd2, 3'd5, POWER_MAX + 8'd1, 1'b1,
                                   pack_result(1'b0, 1'b1, 1'b1, 1'b0), 1'b1));
      foreach (stim_rows[i]) begin
         send_item(stim_rows[i].op, stim_rows[i].secret, stim_rows[i].chan,
                   stim_rows[i].kind, stim_rows[i].power, stim_rows[i].typed,
                   stim_rows[i].want);
         if (stim_rows[i].drain)
            while (tx_phase != PH_IDLE)
               send_tick();
      end

      // random part: fixed corner timings first, then random small timings
      random_base = items_sent;
      setting_no  = 0;
      while (items_sent - random_base < RANDOM_ITEMS) begin
         // idle pattern moves through three thirds of the run
         if (items_sent - random_base < RANDOM_ITEMS / 3) begin
            snd_idle_pct = 29;
            rcv_idle_pct = 55;
         end else if (items_sent - random_base < 2 * RANDOM_ITEMS / 3) begin
            snd_idle_pct = 55;
            rcv_idle_pct = 29;
         end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         case (setting_no)
            // plain timings, no wake pulse
            0: t = make_timing(2, 1, 3, 4, 6, 0, 0, 0);
            // one time derived from period, full wake sequence, zero preamble period
            1: t = make_timing(0, 1, 3, 2, 0, 1, 3, 2);
            // zero time derived, no pre-wait so the pulse comes first, empty preamble
            2: t = make_timing(2, 0, 3, 0, 0, 1, 0, 0);
            // derived one time clamps at zero, no post-wait
            3: t = make_timing(0, 5, 3, 3, 3, 1, 1, 0);
            // zero bit high for its whole period: last tick stays high
            4: t = make_timing(1, 3, 2, 1, 2, 0, 0, 0);
            // period from sum of high times
            5: t = make_timing(3, 1, 0, 5, 2, 1, 2, 1);
            default: t = make_timing($urandom_range(0, 4), $urandom_range(0, 4),
                                     $urandom_range(0, 5), $urandom_range(0, 6),
                                     $urandom_range(0, 6), $urandom_range(0, 1),
                                     $urandom_range(0, 3), $urandom_range(0, 3));
         endcase
         apply_timing(t);
         repeat ($urandom_range(0, 2))
            send_tick();
         run_frame();
         setting_no++;
      end

      // wake pulse straight into a frame of empty symbols, back to back
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      apply_timing(make_timing(0, 0, 0, 0, 0, 1, 0, 0));
      run_frame();

      req_tvalid <= 1'b0;
      while (due_results.size() != 0)
         @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d transactions, %0d frames sent, %0d starts dropped while busy",
               items_sent, frames_done, starts_dropped);
      $display("over %0d timing settings incl. wake pulse, derived bits and empty symbols",
               settings_used);
      if (errors == 0) begin
         $display("pulse_width_rf_message_transmitter_top_test: clean");
      end else begin
         $display("pulse_width_rf_message_transmitter_top_test: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/pwtx_pkg.sv
rtl/pwtx_front.sv
rtl/pwtx_queue.sv
rtl/pwtx_seq.sv
rtl/pulse_width_rf_message_transmitter_top.sv
bench/pulse_width_rf_message_transmitter_top_test.sv
